// ===== rtl/core/lfws_pkg.sv =====
// Shared types, constants and a helper function for the lane-follow wheel steering unit.
package lfws_pkg;

	localparam int SENS_W  = 12;
	localparam int SPEED_W = 8;
	localparam int TIME_W  = 32;
	localparam int TMO_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 3;
	localparam int NUM_WHEELS = 4;

	// Register indexes of the configuration port.
	localparam logic [CIDX_W-1:0] REG_LEFT_THR   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_CENTRE_THR = 3'd1;
	localparam logic [CIDX_W-1:0] REG_RIGHT_THR  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_SPEED_LIM  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_TIMEOUT    = 3'd4;
	localparam logic [CIDX_W-1:0] REG_TURN_GAIN  = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [SENS_W-1:0]  THR_RESET       = 12'd2048;
	localparam logic [SPEED_W-1:0] SPEED_LIM_RESET = 8'd150;
	localparam logic [TMO_W-1:0]   TIMEOUT_RESET   = 16'd1000;
	localparam logic [SPEED_W-1:0] TURN_GAIN_RESET = 8'd192;

	// Speeds at or above this take part in a tank turn.
	localparam logic [SPEED_W-1:0] TANK_MIN_SPEED = 8'd100;

	typedef enum logic [2:0] {
		MODE_PASS   = 3'd0,
		MODE_WEAK   = 3'd1,
		MODE_STRONG = 3'd2,
		MODE_TANK   = 3'd3,
		MODE_STOP   = 3'd4
	} mode_t;

	// Per-item steering decision handed from the control stage to the wheel lanes.
	typedef struct packed {
		mode_t mode;
		logic  dir_left;
		logic  turn_left;
		logic  turn_right;
		logic  warning;
	} ctrl_t;

	function automatic logic [SPEED_W-1:0] sat_speed(input logic [10:0] v);
		logic [SPEED_W-1:0] r;
		r = (v > 11'd255) ? 8'd255 : v[SPEED_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/lfws_if.sv =====
// Valid/ready channel interfaces for the input and result items.
interface lfws_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] sensor_left;
	logic [11:0] sensor_centre;
	logic [11:0] sensor_right;
	logic [7:0]  wheel_a_in;
	logic [7:0]  wheel_b_in;
	logic [7:0]  wheel_c_in;
	logic [7:0]  wheel_d_in;
	logic [31:0] now_ms;

	modport source (output valid, sensor_left, sensor_centre, sensor_right, wheel_a_in,
		wheel_b_in, wheel_c_in, wheel_d_in, now_ms, input ready);
	modport sink (input valid, sensor_left, sensor_centre, sensor_right, wheel_a_in,
		wheel_b_in, wheel_c_in, wheel_d_in, now_ms, output ready);
endinterface

interface lfws_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] wheel_a_out;
	logic [7:0] wheel_b_out;
	logic [7:0] wheel_c_out;
	logic [7:0] wheel_d_out;
	logic       turning_left;
	logic       turning_right;
	logic       warning;

	modport source (output valid, wheel_a_out, wheel_b_out, wheel_c_out, wheel_d_out,
		turning_left, turning_right, warning, input ready);
	modport sink (input valid, wheel_a_out, wheel_b_out, wheel_c_out, wheel_d_out,
		turning_left, turning_right, warning, output ready);
endinterface

// ===== rtl/core/lfws_ctrl.sv =====
// Mode selection, remembered-side state and lane-loss timeout.
module lfws_ctrl #(
	parameter int SENSOR_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [lfws_pkg::SENS_W-1:0] sensor_left,
	input  logic [lfws_pkg::SENS_W-1:0] sensor_centre,
	input  logic [lfws_pkg::SENS_W-1:0] sensor_right,
	input  logic [lfws_pkg::TIME_W-1:0] now_ms,
	input  logic [lfws_pkg::SENS_W-1:0] left_thr,
	input  logic [lfws_pkg::SENS_W-1:0] centre_thr,
	input  logic [lfws_pkg::SENS_W-1:0] right_thr,
	input  logic [lfws_pkg::TMO_W-1:0]  timeout_ms,
	output lfws_pkg::ctrl_t            ctrl
);
	import lfws_pkg::*;

	localparam int SW = (SENSOR_BITS < SENS_W) ? SENSOR_BITS : SENS_W;
	localparam logic [SENS_W-1:0] SENS_MASK = SENS_W'((64'd1 << SW) - 64'd1);

	logic              seen_left_q, seen_right_q;
	logic              turn_left_q, turn_right_q, warning_q;
	logic [TIME_W-1:0] last_q;

	logic              l_on, c_on, r_on;
	logic              seen_left_d, seen_right_d;
	logic              turn_left_d, turn_right_d, warning_d;
	logic [TIME_W-1:0] last_d;
	logic [TIME_W-1:0] elapsed;
	logic              stop;
	mode_t             mode_d;

	assign l_on = (sensor_left & SENS_MASK) < (left_thr & SENS_MASK);
	assign c_on = (sensor_centre & SENS_MASK) < (centre_thr & SENS_MASK);
	assign r_on = (sensor_right & SENS_MASK) < (right_thr & SENS_MASK);

	always_comb begin
		seen_left_d  = seen_left_q;
		seen_right_d = seen_right_q;
		turn_left_d  = turn_left_q;
		turn_right_d = turn_right_q;
		warning_d    = warning_q;
		last_d       = last_q;
		stop         = 1'b0;
		mode_d       = MODE_PASS;
		priority if (c_on) begin
			warning_d = 1'b0;
			if (l_on && r_on) begin
				stop = 1'b1;
			end else begin
				mode_d       = (l_on || r_on) ? MODE_WEAK : MODE_PASS;
				seen_left_d  = l_on;
				seen_right_d = r_on;
				turn_left_d  = 1'b0;
				turn_right_d = 1'b0;
				last_d       = now_ms;
			end
		end else if (l_on || r_on) begin
			mode_d       = MODE_STRONG;
			warning_d    = 1'b0;
			seen_left_d  = l_on;
			seen_right_d = !l_on;
			turn_left_d  = l_on;
			turn_right_d = !l_on;
			last_d       = now_ms;
		end else if (seen_left_q || seen_right_q) begin
			mode_d       = MODE_TANK;
			turn_left_d  = seen_left_q;
			turn_right_d = !seen_left_q;
		end else begin
			warning_d = 1'b1;
		end

		// The timeout is measured against the sighting time as updated by this item.
		elapsed = now_ms - last_d;
		if (elapsed >= {{(TIME_W-TMO_W){1'b0}}, timeout_ms}) begin
			stop = 1'b1;
		end

		if (stop) begin
			mode_d       = MODE_STOP;
			turn_left_d  = 1'b0;
			turn_right_d = 1'b0;
			seen_left_d  = 1'b0;
			seen_right_d = 1'b0;
			warning_d    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_left_q  <= 1'b0;
			seen_right_q <= 1'b0;
			turn_left_q  <= 1'b0;
			turn_right_q <= 1'b0;
			warning_q    <= 1'b0;
			last_q       <= '0;
		end else if (accept) begin
			seen_left_q  <= seen_left_d;
			seen_right_q <= seen_right_d;
			turn_left_q  <= turn_left_d;
			turn_right_q <= turn_right_d;
			warning_q    <= warning_d;
			last_q       <= last_d;
		end
	end

	always_comb begin
		ctrl.mode       = mode_d;
		ctrl.dir_left   = l_on;
		ctrl.turn_left  = turn_left_d;
		ctrl.turn_right = turn_right_d;
		ctrl.warning    = warning_d;
	end

endmodule

// ===== rtl/core/lfws_lane.sv =====
// One wheel lane: applies the selected steering adjustment to a single wheel speed.
module lfws_lane #(
	parameter int WEAK_FACTOR  = 2,
	parameter int WEAK_DIVISOR = 4,
	parameter int HARD_DIVISOR = 2
) (
	input  logic [lfws_pkg::SPEED_W-1:0] speed,
	input  lfws_pkg::mode_t              mode,
	input  logic                         up,
	input  logic [lfws_pkg::SPEED_W-1:0] fast_speed,
	input  logic [lfws_pkg::SPEED_W-1:0] turn_gain,
	output logic [lfws_pkg::SPEED_W-1:0] result
);
	import lfws_pkg::*;

	// Division by a constant is a multiply by a rounded-up reciprocal and a shift;
	// with 16 fraction bits it is exact for every 8-bit speed and divisor up to 64.
	localparam int RECIP_SH = 16;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int PROD_W   = RECIP_W + SPEED_W;
	localparam logic [RECIP_W-1:0] FACTOR_RECIP =
		RECIP_W'(((1 << RECIP_SH) + WEAK_FACTOR - 1) / WEAK_FACTOR);
	localparam logic [RECIP_W-1:0] WEAK_RECIP =
		RECIP_W'(((1 << RECIP_SH) + WEAK_DIVISOR - 1) / WEAK_DIVISOR);
	localparam logic [RECIP_W-1:0] HARD_RECIP =
		RECIP_W'(((1 << RECIP_SH) + HARD_DIVISOR - 1) / HARD_DIVISOR);

	logic [PROD_W-1:0]    fdiv_prod, weak_prod, hard_prod;
	logic [SPEED_W-1:0]   fdiv_q, weak_part, hard_part;
	logic [10:0]          fmul;
	logic [10:0]          weak_up, hard_up;
	logic [2*SPEED_W-1:0] gain_prod;
	logic                 fast;
	logic [SPEED_W-1:0]   weak_res, strong_res, tank_res;

	assign fast = speed > fast_speed;

	assign fdiv_prod = PROD_W'(speed) * PROD_W'(FACTOR_RECIP);
	assign weak_prod = PROD_W'(speed) * PROD_W'(WEAK_RECIP);
	assign hard_prod = PROD_W'(speed) * PROD_W'(HARD_RECIP);
	assign fdiv_q    = fdiv_prod[RECIP_SH +: SPEED_W];
	assign weak_part = weak_prod[RECIP_SH +: SPEED_W];
	assign hard_part = hard_prod[RECIP_SH +: SPEED_W];

	assign fmul    = 11'(speed) * 11'(WEAK_FACTOR);
	assign weak_up = 11'(speed) + 11'(weak_part);
	assign hard_up = 11'(speed) + 11'(hard_part);

	assign gain_prod = {{SPEED_W{1'b0}}, speed} * {{SPEED_W{1'b0}}, turn_gain};

	always_comb begin
		if (fast) begin
			weak_res = up ? sat_speed(fmul) : fdiv_q;
		end else begin
			weak_res = up ? sat_speed(weak_up) : speed - weak_part;
		end
		if (fast) begin
			strong_res = speed;
		end else begin
			strong_res = up ? sat_speed(hard_up) : speed - hard_part;
		end
		tank_res = (speed >= TANK_MIN_SPEED) ? gain_prod[SPEED_W +: SPEED_W] : speed;
	end

	always_comb begin
		unique case (mode)
			MODE_PASS:   result = speed;
			MODE_WEAK:   result = weak_res;
			MODE_STRONG: result = strong_res;
			MODE_TANK:   result = tank_res;
			MODE_STOP:   result = '0;
			default:     result = speed;
		endcase
	end

endmodule

// ===== rtl/core/lane_follow_wheel_steering_unit.sv =====
// Top level of the lane-follow wheel steering unit: config registers, control stage, lanes.
// The unit accepts one item per clock cycle while the output is not stalled, and passes
// each result through the stage-one and output registers. The first stage compares the
// three line sensors against their thresholds, picks the steering mode, checks the
// lane-loss timeout and updates the remembered side and the last sighting time in the
// cycle the item is accepted; the second stage runs four wheel lanes side by side, each
// applying the chosen adjustment to one wheel, and merges their speeds with the turn and
// warning flags into the output register. A stalled output holds its item; the input keeps
// accepting until both stages are full. The user must write the configuration registers
// through the write port only while no item is in flight; the block does not enforce this.
module lane_follow_wheel_steering_unit #(
	parameter int WEAK_FACTOR  = 2,
	parameter int WEAK_DIVISOR = 4,
	parameter int HARD_DIVISOR = 2,
	parameter int SENSOR_BITS  = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lfws_in_if.sink                      in_ch,
	lfws_out_if.source                   out_ch,
	input  logic                         cfg_we,
	input  logic [lfws_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [lfws_pkg::CFG_W-1:0]   cfg_data
);
	import lfws_pkg::*;

	logic [SENS_W-1:0]  left_thr_q, centre_thr_q, right_thr_q;
	logic [SPEED_W-1:0] fast_speed_q, turn_gain_q;
	logic [TMO_W-1:0]   timeout_q;

	logic               accept;
	logic               adv;
	ctrl_t              ctrl;
	ctrl_t              ctrl_s1;
	logic               valid_s1;
	logic [SPEED_W-1:0] wheel_s1 [NUM_WHEELS];
	logic [SPEED_W-1:0] lane_res [NUM_WHEELS];
	logic [SPEED_W-1:0] wheel_q  [NUM_WHEELS];
	logic               turn_left_q, turn_right_q, warning_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_thr_q    <= THR_RESET;
			centre_thr_q  <= THR_RESET;
			right_thr_q   <= THR_RESET;
			fast_speed_q  <= SPEED_LIM_RESET;
			timeout_q     <= TIMEOUT_RESET;
			turn_gain_q   <= TURN_GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEFT_THR:   left_thr_q    <= cfg_data[SENS_W-1:0];
				REG_CENTRE_THR: centre_thr_q  <= cfg_data[SENS_W-1:0];
				REG_RIGHT_THR:  right_thr_q   <= cfg_data[SENS_W-1:0];
				REG_SPEED_LIM:  fast_speed_q  <= cfg_data[SPEED_W-1:0];
				REG_TIMEOUT:    timeout_q     <= cfg_data[TMO_W-1:0];
				REG_TURN_GAIN:  turn_gain_q   <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// The second stage moves whenever the output register is empty or being drained.
	assign adv          = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || adv;
	assign accept       = in_ch.valid && in_ch.ready;

	lfws_ctrl #(
		.SENSOR_BITS(SENSOR_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sensor_left  (in_ch.sensor_left),
		.sensor_centre(in_ch.sensor_centre),
		.sensor_right (in_ch.sensor_right),
		.now_ms       (in_ch.now_ms),
		.left_thr     (left_thr_q),
		.centre_thr   (centre_thr_q),
		.right_thr    (right_thr_q),
		.timeout_ms   (timeout_q),
		.ctrl         (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1     <= ctrl;
			wheel_s1[0] <= in_ch.wheel_a_in;
			wheel_s1[1] <= in_ch.wheel_b_in;
			wheel_s1[2] <= in_ch.wheel_c_in;
			wheel_s1[3] <= in_ch.wheel_d_in;
		end
	end

	// Wheels a and c sit on the left, b and d on the right; with the lane on the
	// left the left wheels slow down and the right wheels speed up.
	for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
		lfws_lane #(
			.WEAK_FACTOR (WEAK_FACTOR),
			.WEAK_DIVISOR(WEAK_DIVISOR),
			.HARD_DIVISOR(HARD_DIVISOR)
		) u_lane (
			.speed      (wheel_s1[i]),
			.mode       (ctrl_s1.mode),
			.up         ((i % 2 == 1) ? ctrl_s1.dir_left : !ctrl_s1.dir_left),
			.fast_speed (fast_speed_q),
			.turn_gain  (turn_gain_q),
			.result     (lane_res[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			wheel_q      <= lane_res;
			turn_left_q  <= ctrl_s1.turn_left;
			turn_right_q <= ctrl_s1.turn_right;
			warning_q    <= ctrl_s1.warning;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.wheel_a_out   = wheel_q[0];
	assign out_ch.wheel_b_out   = wheel_q[1];
	assign out_ch.wheel_c_out   = wheel_q[2];
	assign out_ch.wheel_d_out   = wheel_q[3];
	assign out_ch.turning_left  = turn_left_q;
	assign out_ch.turning_right = turn_right_q;
	assign out_ch.warning       = warning_q;

endmodule

// ===== rtl/core/lfws_checker.sv =====
// Port-level checks for the lane-follow wheel steering unit, bound to its top level.
module lfws_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] wheel_a_out,
	input logic [7:0] wheel_b_out,
	input logic [7:0] wheel_c_out,
	input logic [7:0] wheel_d_out,
	input logic       turning_left,
	input logic       turning_right,
	input logic       warning
);

	// A turn is only ever toward one side.
	a_one_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(turning_left && turning_right))
		else $error("both turn flags set on one item");

	// A turn in progress always follows a sighting, which clears the warning.
	a_turn_no_warn: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (turning_left || turning_right)) |-> !warning)
		else $error("warning raised during a turn");

	// The input only stalls when both stages are full and the output is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output back-pressure");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(wheel_a_out)
			&& $stable(wheel_b_out) && $stable(wheel_c_out) && $stable(wheel_d_out)
			&& $stable(turning_left) && $stable(turning_right) && $stable(warning)))
		else $error("stalled result item changed");

endmodule

bind lane_follow_wheel_steering_unit lfws_checker u_lfws_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.wheel_a_out  (out_ch.wheel_a_out),
	.wheel_b_out  (out_ch.wheel_b_out),
	.wheel_c_out  (out_ch.wheel_c_out),
	.wheel_d_out  (out_ch.wheel_d_out),
	.turning_left (out_ch.turning_left),
	.turning_right(out_ch.turning_right),
	.warning      (out_ch.warning)
);

// ===== tb/lane_follow_wheel_steering_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the lane-follow wheel steering unit: directed and random ticks checked against a predictor.
module lane_follow_wheel_steering_unit_tb;
	import lfws_pkg::*;

	localparam int WEAK_FACTOR  = 2;
	localparam int WEAK_DIVISOR = 4;
	localparam int HARD_DIVISOR = 2;
	localparam int SENSOR_BITS  = 12;

	typedef struct packed {
		logic [SENS_W-1:0]  sensor_left;
		logic [SENS_W-1:0]  sensor_centre;
		logic [SENS_W-1:0]  sensor_right;
		logic [SPEED_W-1:0] wheel_a;
		logic [SPEED_W-1:0] wheel_b;
		logic [SPEED_W-1:0] wheel_c;
		logic [SPEED_W-1:0] wheel_d;
		logic [TIME_W-1:0]  now_ms;
	} tick_t;

	typedef struct packed {
		logic [SPEED_W-1:0] wheel_a;
		logic [SPEED_W-1:0] wheel_b;
		logic [SPEED_W-1:0] wheel_c;
		logic [SPEED_W-1:0] wheel_d;
		logic               turning_left;
		logic               turning_right;
		logic               warning;
	} steer_t;

	class steering_scoreboard;
		logic [SENS_W-1:0]  left_thr, centre_thr, right_thr;
		logic [SPEED_W-1:0] speed_lim, turn_gain;
		logic [TMO_W-1:0]   timeout;
		logic               seen_left, seen_right, turn_left, turn_right, warn;
		logic [TIME_W-1:0]  last_sighting;
		steer_t             expected_steer[$];
		int                 errors;

		function new();
			left_thr = THR_RESET;
			centre_thr = THR_RESET;
			right_thr = THR_RESET;
			speed_lim = SPEED_LIM_RESET;
			timeout = TIMEOUT_RESET;
			turn_gain = TURN_GAIN_RESET;
			seen_left = 1'b0;
			seen_right = 1'b0;
			turn_left = 1'b0;
			turn_right = 1'b0;
			warn = 1'b0;
			last_sighting = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
			unique case (idx)
			REG_LEFT_THR: left_thr = val[SENS_W-1:0];
			REG_CENTRE_THR: centre_thr = val[SENS_W-1:0];
			REG_RIGHT_THR: right_thr = val[SENS_W-1:0];
			REG_SPEED_LIM: speed_lim = val[SPEED_W-1:0];
			REG_TIMEOUT: timeout = val[TMO_W-1:0];
			REG_TURN_GAIN: turn_gain = val[SPEED_W-1:0];
			default: ;
			endcase
		endfunction

		function int unsigned clamp_speed(int unsigned v);
			return (v > 255) ? 255 : v;
		endfunction

		function int unsigned weak_speed(int unsigned s, logic up);
			if (s > speed_lim)
				return up ? clamp_speed(s * WEAK_FACTOR) : s / WEAK_FACTOR;
			if (up)
				return clamp_speed(s + s / WEAK_DIVISOR);
			return s - s / WEAK_DIVISOR;
		endfunction

		function int unsigned strong_speed(int unsigned s, logic up);
			if (s > speed_lim)
				return s;
			if (up)
				return clamp_speed(s + s / HARD_DIVISOR);
			return s - s / HARD_DIVISOR;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		// Updates the steering state for one accepted tick and queues the expected result.
		function void note_tick(tick_t t);
			logic              l_on, c_on, r_on, halt, up;
			int unsigned       sp[4];
			logic [TIME_W-1:0] since;
			steer_t            e;
			l_on = t.sensor_left < left_thr;
			c_on = t.sensor_centre < centre_thr;
			r_on = t.sensor_right < right_thr;
			sp[0] = t.wheel_a;
			sp[1] = t.wheel_b;
			sp[2] = t.wheel_c;
			sp[3] = t.wheel_d;
			halt = 1'b0;
			// Wheels a and c are on the left side, b and d on the right.
			if (c_on) begin
				warn = 1'b0;
				if (l_on && r_on) begin
					halt = 1'b1;
				end else begin
					if (l_on || r_on) begin
						for (int i = 0; i < 4; i++) begin
							up = ((i % 2) == 1) == l_on;
							sp[i] = weak_speed(sp[i], up);
						end
					end
					seen_left = l_on;
					seen_right = r_on;
					turn_left = 1'b0;
					turn_right = 1'b0;
					last_sighting = t.now_ms;
				end
			end else if (l_on || r_on) begin
				for (int i = 0; i < 4; i++) begin
					up = ((i % 2) == 1) == l_on;
					sp[i] = strong_speed(sp[i], up);
				end
				warn = 1'b0;
				seen_left = l_on;
				seen_right = !l_on;
				turn_left = l_on;
				turn_right = !l_on;
				last_sighting = t.now_ms;
			end else if (seen_left || seen_right) begin
				for (int i = 0; i < 4; i++)
					if (sp[i] >= TANK_MIN_SPEED)
						sp[i] = (sp[i] * turn_gain) >> 8;
				turn_left = seen_left;
				turn_right = !seen_left;
			end else begin
				warn = 1'b1;
			end
			since = t.now_ms - last_sighting;
			if (since >= {16'd0, timeout})
				halt = 1'b1;
			if (halt) begin
				for (int i = 0; i < 4; i++)
					sp[i] = 0;
				turn_left = 1'b0;
				turn_right = 1'b0;
				seen_left = 1'b0;
				seen_right = 1'b0;
				warn = 1'b1;
			end
			e.wheel_a = 8'(sp[0]);
			e.wheel_b = 8'(sp[1]);
			e.wheel_c = 8'(sp[2]);
			e.wheel_d = 8'(sp[3]);
			e.turning_left = turn_left;
			e.turning_right = turn_right;
			e.warning = warn;
			expected_steer.push_back(e);
		endfunction

		function void check_steering(steer_t got);
			steer_t e;
			if (expected_steer.size() == 0) begin
				report($sformatf("unexpected result: a=%0d b=%0d c=%0d d=%0d tl=%0b tr=%0b w=%0b",
					got.wheel_a, got.wheel_b, got.wheel_c, got.wheel_d,
					got.turning_left, got.turning_right, got.warning));
				return;
			end
			e = expected_steer.pop_front();
			if (got.wheel_a !== e.wheel_a || got.wheel_b !== e.wheel_b ||
				got.wheel_c !== e.wheel_c || got.wheel_d !== e.wheel_d ||
				got.turning_left !== e.turning_left || got.turning_right !== e.turning_right ||
				got.warning !== e.warning)
				report($sformatf({"steering mismatch: expected a=%0d b=%0d c=%0d d=%0d tl=%0b ",
					"tr=%0b w=%0b, got a=%0d b=%0d c=%0d d=%0d tl=%0b tr=%0b w=%0b"},
					e.wheel_a, e.wheel_b, e.wheel_c, e.wheel_d,
					e.turning_left, e.turning_right, e.warning,
					got.wheel_a, got.wheel_b, got.wheel_c, got.wheel_d,
					got.turning_left, got.turning_right, got.warning));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic tx_quiet = 1'b0;
	logic rx_quiet = 1'b0;
	logic [TIME_W-1:0] tick_ms;

	steering_scoreboard sb = new();

	lfws_in_if  in_ch();
	lfws_out_if out_ch();

	lane_follow_wheel_steering_unit #(
		.WEAK_FACTOR(WEAK_FACTOR),
		.WEAK_DIVISOR(WEAK_DIVISOR),
		.HARD_DIVISOR(HARD_DIVISOR),
		.SENSOR_BITS(SENSOR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// The result side ready is driven only here, from the first clock edge on.
	always @(posedge clk) begin
		steer_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.wheel_a_out, out_ch.wheel_b_out, out_ch.wheel_c_out,
				out_ch.wheel_d_out, out_ch.turning_left, out_ch.turning_right, out_ch.warning};
			sb.check_steering(got);
		end
		out_ch.ready <= rx_quiet || ($urandom_range(0, 99) >= 16);
	end

	task automatic send_tick(input tick_t t);
		if (!tx_quiet && $urandom_range(0, 99) < 16) begin
			in_ch.valid <= 1'b0;
			repeat (($urandom_range(0, 7) == 0) ? 4 : 1) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sensor_left <= t.sensor_left;
		in_ch.sensor_centre <= t.sensor_centre;
		in_ch.sensor_right <= t.sensor_right;
		in_ch.wheel_a_in <= t.wheel_a;
		in_ch.wheel_b_in <= t.wheel_b;
		in_ch.wheel_c_in <= t.wheel_c;
		in_ch.wheel_d_in <= t.wheel_d;
		in_ch.now_ms <= t.now_ms;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_tick(t);
	endtask

	// Holds the input back until every expected result is out, then lets the pipeline settle.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (sb.expected_steer.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Upper data bits beyond a register's width carry junk, which the block must drop.
	task automatic set_config(input logic [SENS_W-1:0] lt, input logic [SENS_W-1:0] ct,
		input logic [SENS_W-1:0] rt, input logic [SPEED_W-1:0] lim,
		input logic [TMO_W-1:0] tmo, input logic [SPEED_W-1:0] gain);
		write_reg(REG_LEFT_THR, {4'($urandom), lt});
		write_reg(REG_CENTRE_THR, {4'($urandom), ct});
		write_reg(REG_RIGHT_THR, {4'($urandom), rt});
		write_reg(REG_SPEED_LIM, {8'($urandom), lim});
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_TURN_GAIN, {8'($urandom), gain});
		cfg_we <= 1'b0;
	endtask

	function automatic tick_t make_tick(int unsigned sl, int unsigned sc, int unsigned sr,
		int unsigned w0, int unsigned w1, int unsigned w2, int unsigned w3,
		logic [TIME_W-1:0] now);
		tick_t t;
		t.sensor_left = SENS_W'(sl);
		t.sensor_centre = SENS_W'(sc);
		t.sensor_right = SENS_W'(sr);
		t.wheel_a = SPEED_W'(w0);
		t.wheel_b = SPEED_W'(w1);
		t.wheel_c = SPEED_W'(w2);
		t.wheel_d = SPEED_W'(w3);
		t.now_ms = now;
		return t;
	endfunction

	function automatic logic [SENS_W-1:0] pick_sensor(logic [SENS_W-1:0] thr, bit on);
		int unsigned r;
		r = $urandom_range(0, 15);
		if (on && thr != 0) begin
			if (r == 0)
				return thr - 1'b1;
			if (r == 1)
				return '0;
			return SENS_W'($urandom_range(0, thr - 1));
		end
		if (r == 0)
			return thr;
		if (r == 1)
			return '1;
		return SENS_W'($urandom_range(thr, 4095));
	endfunction

	function automatic logic [SPEED_W-1:0] pick_speed();
		unique case ($urandom_range(0, 9))
		0: return sb.speed_lim;
		1: return sb.speed_lim + 1'b1;
		2: return TANK_MIN_SPEED;
		3: return TANK_MIN_SPEED - 1'b1;
		4: return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
		default: return SPEED_W'($urandom);
		endcase
	endfunction

	// Mostly small steps, with some ticks placed right at the timeout edge and some far jumps.
	function automatic logic [TIME_W-1:0] pick_time(logic [TIME_W-1:0] prev);
		int unsigned       r;
		logic [TIME_W-1:0] tmo;
		tmo = {16'd0, sb.timeout};
		r = $urandom_range(0, 99);
		if (r < 5)
			return sb.last_sighting + tmo - 1;
		if (r < 10)
			return sb.last_sighting + tmo;
		if (r < 12)
			return $urandom;
		if (r < 14)
			return prev + tmo + $urandom_range(0, 1000);
		return prev + $urandom_range(0, tmo / 4);
	endfunction

	task automatic send_random_ticks(input int count);
		tick_t       t;
		bit          l, c, r;
		int unsigned p;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(0, 99);
			l = (p >= 10 && p < 22) || (p >= 34 && p < 46) || (p >= 78 && p < 88);
			c = p < 34 || (p >= 78 && p < 83);
			r = (p >= 22 && p < 34) || (p >= 46 && p < 58) || (p >= 78 && p < 88);
			if (p >= 88) begin
				t.sensor_left = SENS_W'($urandom);
				t.sensor_centre = SENS_W'($urandom);
				t.sensor_right = SENS_W'($urandom);
			end else begin
				t.sensor_left = pick_sensor(sb.left_thr, l);
				t.sensor_centre = pick_sensor(sb.centre_thr, c);
				t.sensor_right = pick_sensor(sb.right_thr, r);
			end
			t.wheel_a = pick_speed();
			t.wheel_b = pick_speed();
			t.wheel_c = pick_speed();
			t.wheel_d = pick_speed();
			tick_ms = pick_time(tick_ms);
			t.now_ms = tick_ms;
			if (i == count / 2)
				wait_idle();
			send_tick(t);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_LEFT_THR;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.sensor_left <= '0;
		in_ch.sensor_centre <= '0;
		in_ch.sensor_right <= '0;
		in_ch.wheel_a_in <= '0;
		in_ch.wheel_b_in <= '0;
		in_ch.wheel_c_in <= '0;
		in_ch.wheel_d_in <= '0;
		in_ch.now_ms <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every steering mode under the reset settings, threshold edges, the timeout edge
		// and a wrap of the millisecond time.
		send_tick(make_tick(3000, 3000, 3000, 10, 20, 30, 40, 10));
		send_tick(make_tick(4095, 0, 2048, 0, 255, 150, 151, 20));
		send_tick(make_tick(2047, 100, 3000, 151, 150, 255, 0, 30));
		send_tick(make_tick(3000, 2047, 0, 255, 1, 151, 100, 40));
		send_tick(make_tick(5, 4000, 2500, 150, 151, 255, 3, 50));
		send_tick(make_tick(3000, 3000, 3000, 99, 100, 255, 200, 60));
		send_tick(make_tick(2048, 2048, 1, 100, 255, 99, 0, 70));
		send_tick(make_tick(3000, 3000, 3000, 100, 255, 99, 0, 80));
		send_tick(make_tick(4095, 4095, 4095, 128, 64, 255, 101, 90));
		send_tick(make_tick(0, 0, 0, 200, 200, 200, 200, 100));
		send_tick(make_tick(3000, 3000, 3000, 200, 200, 200, 200, 110));
		send_tick(make_tick(10, 3000, 10, 120, 160, 255, 50, 120));
		send_tick(make_tick(3000, 3000, 3000, 120, 160, 255, 50, 1119));
		send_tick(make_tick(3000, 3000, 3000, 120, 160, 255, 50, 1120));
		send_tick(make_tick(3000, 5, 3000, 77, 88, 99, 111, 1130));
		send_tick(make_tick(3000, 3000, 3000, 150, 150, 150, 150, 32'hFFFF_FFF0));
		send_tick(make_tick(1000, 1000, 3000, 150, 150, 150, 150, 32'hFFFF_FFF8));
		send_tick(make_tick(3000, 3000, 3000, 150, 255, 100, 99, 32'd5));
		tick_ms = 32'd5;

		send_random_ticks(260);

		wait_idle();
		set_config(12'd0, 12'd0, 12'd0, 8'd0, 16'd0, 8'd0);
		send_random_ticks(120);

		wait_idle();
		tx_quiet <= 1'b1;
		rx_quiet <= 1'b1;
		set_config(12'd4095, 12'd4095, 12'd4095, 8'd255, 16'd65535, 8'd255);
		send_random_ticks(275);
		tx_quiet <= 1'b0;
		rx_quiet <= 1'b0;

		wait_idle();
		set_config(SENS_W'($urandom), SENS_W'($urandom), SENS_W'($urandom),
			SPEED_W'($urandom), TMO_W'($urandom_range(1, 20)), SPEED_W'($urandom));
		send_random_ticks(275);

		wait_idle();
		tick_ms = 32'hFFFF_F000;
		set_config(SENS_W'($urandom), SENS_W'($urandom), SENS_W'($urandom),
			SPEED_W'($urandom), TMO_W'($urandom), SPEED_W'($urandom));
		send_random_ticks(275);

		wait_idle();
		set_config(12'd1, 12'd1, 12'd1, 8'd99, 16'd65535, 8'd128);
		send_random_ticks(275);

		wait_idle();
		set_config(SENS_W'($urandom_range(1024, 3072)), SENS_W'($urandom_range(1024, 3072)),
			SENS_W'($urandom_range(1024, 3072)), 8'd100, 16'd3000, 8'd1);
		send_random_ticks(275);

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_steer.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
